>>> design/plp_pkg.sv
// Package for the positional list: capacity, field widths, status codes
// and the control struct that the top level hands to every storage cell.
// No dependencies.
package plp_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] pidx;
  } plp_ctrl_t;

endpackage

>>> design/plp_cell.sv
// One storage cell of the positional list row.
// Depends on plp_pkg for widths and the control struct.
module plp_cell import plp_pkg::*; (
  input  logic                     clk,
  input  logic [POS_W-1:0]         idx,
  input  plp_ctrl_t                ctrl,
  input  logic signed [DATA_W-1:0] ins_value,
  input  logic signed [DATA_W-1:0] lo_value,
  input  logic signed [DATA_W-1:0] hi_value,
  output logic signed [DATA_W-1:0] q,
  output logic                     sel
);

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;

  assign sel = (idx == ctrl.pidx);
  assign q   = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins) begin
      if (idx == ctrl.pidx) begin
        value_nxt = ins_value;
      end else if (idx > ctrl.pidx) begin
        value_nxt = lo_value;
      end
    end else if (ctrl.del) begin
      if (idx >= ctrl.pidx) begin
        value_nxt = hi_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

>>> design/positional_list_insert_delete.sv
// A result is registered and appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while out_tready takes each result; the whole
// row of cells shifts in parallel, and the output register frees as soon as its result is taken.
// Reset clears the element count and the output valid; cell contents stay
// undefined until written. Depends on plp_pkg and plp_cell.
module positional_list_insert_delete import plp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] value
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] removed_value, [39:32] list_length
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      out_valid_r;
  status_t                   out_status_r, status_nxt;
  logic signed [DATA_W-1:0]  out_removed_r, removed_nxt;
  logic [POS_W-1:0]          out_len_r;

  logic                      accept;
  logic                      cmd;
  logic [POS_W-1:0]          position;
  logic signed [DATA_W-1:0]  value;
  plp_ctrl_t                 ctrl;

  logic signed [DATA_W-1:0]  cell_q   [CAPACITY];
  logic                      cell_sel [CAPACITY];
  logic signed [DATA_W-1:0]  picked;

  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign cmd       = in_tuser[0];
  assign position  = in_tdata[7:0];
  assign value     = in_tdata[39:8];

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.pidx  = position - POS_W'(1);
    status_nxt = ST_OK;
    count_nxt  = count_r;
    if (cmd == CMD_INSERT) begin
      if (position == '0 || {1'b0, position} > (9'(count_r) + 9'd1)) begin
        status_nxt = ST_RANGE;
      end else if (count_r == CNT_W'(CAPACITY)) begin
        status_nxt = ST_FULL;
      end else begin
        ctrl.ins  = accept;
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (position == '0 || {1'b0, position} > 9'(count_r)) begin
        status_nxt = ST_RANGE;
      end else begin
        ctrl.del  = accept;
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] lo_v, hi_v;
    if (i == 0) begin : g_first
      assign lo_v = '0;
    end else begin : g_lo
      assign lo_v = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign hi_v = '0;
    end else begin : g_hi
      assign hi_v = cell_q[i+1];
    end
    plp_cell u_cell (
      .clk       (clk),
      .idx       (POS_W'(i)),
      .ctrl      (ctrl),
      .ins_value (value),
      .lo_value  (lo_v),
      .hi_value  (hi_v),
      .q         (cell_q[i]),
      .sel       (cell_sel[i])
    );
  end

  always_comb begin
    picked = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      picked = picked | (cell_sel[i] ? cell_q[i] : '0);
    end
    removed_nxt = (cmd == CMD_DELETE && status_nxt == ST_OK) ? picked : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r  <= status_nxt;
      out_removed_r <= removed_nxt;
      out_len_r     <= POS_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_removed_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count exceeds capacity");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[39:32] == POS_W'(CAPACITY))
    else $error("full status reported while list not full");

  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[31:0] == '0)
    else $error("nonzero removed value on failed transaction");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ctrl.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("count did not advance after insert");
`endif

endmodule
